// ----- rtl/sle_pkg.sv -----
package sle_pkg;

  localparam int unsigned SC_ROM_SIZE   = 58;
  localparam int unsigned ROM_IDX_W     = 6;
  localparam logic [7:0]  CH_BACKSPACE  = 8'h08;
  localparam logic [7:0]  CH_NEWLINE    = 8'h0A;
  localparam logic [7:0]  MAX_LEN_RESET = 8'd255;
  localparam int unsigned QUEUE_DEPTH   = 2;

  // Result kinds as they appear on the output channel.
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_STORE = 2'd1,
    EV_ERASE = 2'd2,
    EV_END   = 2'd3
  } ev_kind_t;

  // What the front part decided an accepted scan code means.
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_CHAR,
    CMD_BACKSPACE,
    CMD_NEWLINE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] ch;
  } cmd_entry_t;

  // Set-1 make code to character map; entry 0 first.
  localparam logic [7:0] SC_ROM [SC_ROM_SIZE] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h29, 8'h3D, 8'h08, 8'h09, 8'h61, 8'h7A, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h22, 8'h5D, 8'h0A, 8'h00,
    8'h71, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h5D,
    8'h25, 8'h2A, 8'h00, 8'h00, 8'h77, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h3B, 8'h6D, 8'h3A, 8'h21, 8'h00, 8'h2A, 8'h00, 8'h20
  };

  function automatic logic [7:0] map_code(input logic [7:0] code);
    logic [7:0] ch;
    ch = 8'h00;
    if (code < 8'(SC_ROM_SIZE)) begin
      ch = SC_ROM[code[ROM_IDX_W-1:0]];
    end
    return ch;
  endfunction

endpackage

// ----- rtl/sle_front.sv -----
module sle_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          scan_byte,
  output sle_pkg::cmd_entry_t cmd
);

  logic [7:0] prev_make_r;
  logic [7:0] prev_make_nxt;
  logic       is_release;
  logic       is_repeat;
  logic [7:0] ch;

  assign is_release = scan_byte[7];
  assign is_repeat  = (scan_byte == prev_make_r);
  assign ch         = sle_pkg::map_code(scan_byte);

  always_comb begin
    prev_make_nxt = prev_make_r;
    if (accept) begin
      if (is_release) begin
        prev_make_nxt = 8'h00;
      end else if (!is_repeat) begin
        prev_make_nxt = scan_byte;
      end
    end
  end

  always_comb begin
    cmd.ch = ch;
    if (is_release || is_repeat || ch == 8'h00) begin
      cmd.kind = sle_pkg::CMD_NONE;
    end else if (ch == sle_pkg::CH_NEWLINE) begin
      cmd.kind = sle_pkg::CMD_NEWLINE;
    end else if (ch == sle_pkg::CH_BACKSPACE) begin
      cmd.kind = sle_pkg::CMD_BACKSPACE;
    end else begin
      cmd.kind = sle_pkg::CMD_CHAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_make_r <= 8'h00;
    end else begin
      prev_make_r <= prev_make_nxt;
    end
  end

endmodule

// ----- rtl/sle_queue.sv -----
module sle_queue #(
  parameter int unsigned DEPTH = sle_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sle_pkg::cmd_entry_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output sle_pkg::cmd_entry_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sle_pkg::cmd_entry_t slots_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !not_empty |-> !pop) else $error("queue read while empty");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && pop) |=> $stable(count_r)) else $error("count moved on push and pop");
`endif

endmodule

// ----- rtl/sle_back.sv -----
module sle_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  input  logic                cmd_valid,
  input  sle_pkg::cmd_entry_t cmd,
  output logic                cmd_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output sle_pkg::ev_kind_t   event_kind,
  output logic [7:0]          char_out,
  output logic [7:0]          buffer_index
);

  logic [7:0]        max_len_r;
  logic [7:0]        pos_r, pos_nxt;
  logic              out_valid_r, out_valid_nxt;
  sle_pkg::ev_kind_t kind_r, kind_nxt;
  logic [7:0]        char_r, char_nxt;
  logic [7:0]        idx_r, idx_nxt;

  assign cmd_pop = cmd_valid && (!out_valid_r || out_ready);

  always_comb begin
    pos_nxt  = pos_r;
    kind_nxt = sle_pkg::EV_NONE;
    char_nxt = 8'h00;
    idx_nxt  = 8'h00;
    unique case (cmd.kind)
      sle_pkg::CMD_CHAR: begin
        if (pos_r < max_len_r) begin
          kind_nxt = sle_pkg::EV_STORE;
          char_nxt = cmd.ch;
          idx_nxt  = pos_r;
          pos_nxt  = pos_r + 8'd1;
        end
      end
      sle_pkg::CMD_NEWLINE: begin
        kind_nxt = sle_pkg::EV_END;
        idx_nxt  = pos_r;
        pos_nxt  = 8'h00;
      end
      sle_pkg::CMD_BACKSPACE: begin
        if (pos_r != 8'h00) begin
          kind_nxt = sle_pkg::EV_ERASE;
          idx_nxt  = pos_r - 8'd1;
          pos_nxt  = pos_r - 8'd1;
        end
      end
      sle_pkg::CMD_NONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r   <= sle_pkg::MAX_LEN_RESET;
      pos_r       <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
      if (cmd_pop) begin
        pos_r <= pos_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      kind_r <= kind_nxt;
      char_r <= char_nxt;
      idx_r  <= idx_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign event_kind   = kind_r;
  assign char_out     = char_r;
  assign buffer_index = idx_r;

`ifndef SYNTH
  a_store_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_pop && kind_nxt == sle_pkg::EV_STORE) |=> (pos_r == $past(pos_r) + 8'd1))
    else $error("store did not advance the position");
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_pop && kind_nxt == sle_pkg::EV_END) |=> (pos_r == 8'h00))
    else $error("line end did not clear the position");
  a_pos_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd_pop |=> $stable(pos_r)) else $error("position moved without a command");
  a_char_only_on_store: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r != sle_pkg::EV_STORE) |-> (char_r == 8'h00))
    else $error("character present on a non-store result");
`endif

endmodule

// ----- rtl/scancode_line_editor.sv -----
// Channel   Direction  Handshake             Contents
// in_       slave      in_tvalid/in_tready   scan_byte
// out_      master     out_tvalid/out_tready event_kind, char_out, buffer_index
// cfg_      write      cfg_wr_en             max_line_length
//
// One scan code per cycle is sustained while results are taken; a result passes
// through the queue into the output register and is held there until taken.
// The front classifies each code in the cycle it is accepted; the back applies
// it to the line position when it leaves the two-entry queue.
// Reset clears the remembered make code, the queue, the line position and the
// output valid flag, and sets the line limit to 255. A stalled output fills the queue,
// after which in_tready drops until a result is taken.
module scancode_line_editor #(
  parameter int unsigned QUEUE_DEPTH = sle_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] scan_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [1:0] event_kind, [9:2] char_out,
                                   // [17:10] buffer_index, [23:18] zero
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data  // max_line_length
);

  sle_pkg::cmd_entry_t front_cmd;
  sle_pkg::cmd_entry_t queue_head;
  sle_pkg::ev_kind_t   event_kind;
  logic                queue_full;
  logic                queue_not_empty;
  logic                queue_pop;
  logic                in_accept;
  logic [7:0]          char_out;
  logic [7:0]          buffer_index;

  // Every accepted code produces exactly one queue entry, even when it
  // turns out to mean nothing, so that each transaction gets one result.
  assign in_tready = !queue_full;
  assign in_accept = in_tvalid && in_tready;

  sle_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .scan_byte (in_tdata),
    .cmd       (front_cmd)
  );

  sle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data (front_cmd),
    .full      (queue_full),
    .pop       (queue_pop),
    .not_empty (queue_not_empty),
    .head      (queue_head)
  );

  // The back owns the line position and the limit register.
  sle_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .cmd_valid    (queue_not_empty),
    .cmd          (queue_head),
    .cmd_pop      (queue_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .event_kind   (event_kind),
    .char_out     (char_out),
    .buffer_index (buffer_index)
  );

  assign out_tdata = {6'b0, buffer_index, char_out, event_kind};

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  // One result as it travels on out_tdata, lowest field last in the list.
  typedef struct packed {
    logic [5:0]         pad;
    logic [7:0]         pos;
    logic [7:0]         ch;
    sle_pkg::ev_kind_t  kind;
  } line_event_t;

  // Set-1 make code to character table, entry 0 first, kept apart from the
  // block's own table so that a wrong entry there shows up as a mismatch.
  localparam logic [7:0] KEYMAP [sle_pkg::SC_ROM_SIZE] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h29, 8'h3D, 8'h08, 8'h09, 8'h61, 8'h7A, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h22, 8'h5D, 8'h0A, 8'h00,
    8'h71, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h5D,
    8'h25, 8'h2A, 8'h00, 8'h00, 8'h77, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h3B, 8'h6D, 8'h3A, 8'h21, 8'h00, 8'h2A, 8'h00, 8'h20
  };

  // Scan codes used by the directed tests.
  localparam logic [7:0] KEY_ESC        = 8'h01;
  localparam logic [7:0] KEY_BACKSPACE  = 8'h0E;
  localparam logic [7:0] KEY_TAB        = 8'h0F;
  localparam logic [7:0] KEY_A          = 8'h10;
  localparam logic [7:0] KEY_Z          = 8'h11;
  localparam logic [7:0] KEY_E          = 8'h12;
  localparam logic [7:0] KEY_R          = 8'h13;
  localparam logic [7:0] KEY_T          = 8'h14;
  localparam logic [7:0] KEY_Y          = 8'h15;
  localparam logic [7:0] KEY_ENTER      = 8'h1C;
  localparam logic [7:0] KEY_CTRL       = 8'h1D;
  localparam logic [7:0] KEY_SPACE      = 8'h39;
  localparam logic [7:0] FIRST_UNMAPPED = 8'h3A;
  localparam logic [7:0] RELEASE_BIT    = 8'h80;

  localparam int IDLE_PCT    = 12;
  localparam int MAX_REPORTS = 10;

  // Every input starts at a known value; reset is held low from time zero.
  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = 8'h00;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_wr_en   = 1'b0;
  logic [7:0]  cfg_wr_data = 8'h00;

  // Predictor state: the remembered make code, the next free buffer slot and
  // the line limit as last written.
  logic [7:0] last_make;
  logic [7:0] cursor;
  logic [7:0] line_limit;

  line_event_t expected_events[$];
  int          errors        = 0;
  int          scans_sent    = 0;
  int          kinds_seen[4] = '{0, 0, 0, 0};
  int          limits_used   = 0;

  // While set, neither side inserts idle cycles.
  bit no_idle = 1'b0;

  scancode_line_editor dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // A hard stop in case a handshake never completes.
  initial begin
    #2_400_000;
    $display("tb_top: FAIL");
    $finish;
  end

  // Applies one scan code to the predicted editor state and returns the
  // event that the block must report for it. A release forgets the held key,
  // a make equal to the held one is auto-repeat, everything else is looked up
  // and turned into a store, an erase, a line end or nothing.
  function automatic line_event_t edit_line(input logic [7:0] code);
    line_event_t ev;
    logic [7:0]  ch;
    ev = '0;
    ev.kind = sle_pkg::EV_NONE;
    if (code[7]) begin
      last_make = 8'h00;
    end else if (code != last_make) begin
      last_make = code;
      ch = (code < 8'(sle_pkg::SC_ROM_SIZE)) ? KEYMAP[code] : 8'h00;
      if (ch == 8'h00) begin
        // Unmapped key: remembered, but nothing happens to the line.
      end else if (ch == sle_pkg::CH_NEWLINE) begin
        ev.kind = sle_pkg::EV_END;
        ev.pos  = cursor;
        cursor  = 8'h00;
      end else if (ch == sle_pkg::CH_BACKSPACE) begin
        // Backspace on an empty line does nothing.
        if (cursor != 8'h00) begin
          cursor  = cursor - 8'd1;
          ev.kind = sle_pkg::EV_ERASE;
          ev.pos  = cursor;
        end
      end else if (cursor < line_limit) begin
        ev.kind = sle_pkg::EV_STORE;
        ev.ch   = ch;
        ev.pos  = cursor;
        cursor  = cursor + 8'd1;
      end
    end
    return ev;
  endfunction

  // Offers one scan code and waits for the transaction. The valid stays high
  // afterwards so that back-to-back codes need no second assignment in one
  // step; only an idle cycle or a drain lowers it.
  task automatic send_scan(input logic [7:0] code);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= code;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_events.push_back(edit_line(code));
    scans_sent++;
  endtask

  // Stops offering codes and waits until every predicted event has come out.
  task automatic drain_events();
    in_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
  endtask

  // The limit is only changed with the block idle, so the predictor can
  // switch over at the same moment.
  task automatic write_limit(input logic [7:0] value);
    drain_events();
    repeat (2) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    line_limit = value;
    limits_used++;
  endtask

  // Random typing. Most keys are ordinary make codes, some are followed by
  // their release and some are repeated as auto-repeat; a few codes are raw
  // bytes from the whole 8-bit range.
  task automatic type_randomly(input int keys, input int enter_pct, input int bs_pct);
    int         roll;
    logic [7:0] code;
    repeat (keys) begin
      roll = $urandom_range(99);
      if (roll < enter_pct) begin
        code = KEY_ENTER;
      end else if (roll < enter_pct + bs_pct) begin
        code = KEY_BACKSPACE;
      end else if (roll < 92) begin
        code = 8'($urandom_range(1, sle_pkg::SC_ROM_SIZE - 1));
      end else begin
        code = 8'($urandom_range(255));
      end
      send_scan(code);
      roll = $urandom_range(99);
      if (roll < 45) begin
        send_scan(code | RELEASE_BIT);
      end else if (roll < 52) begin
        send_scan(code);
      end
    end
  endtask

  // Reset state and every kind of key under the reset limit of 255.
  task automatic test_reset_and_keys();
    send_scan(8'h00);                    // zero right after reset is a repeat
    send_scan(KEY_A);                    // stored at slot 0
    send_scan(KEY_A);                    // auto-repeat, ignored
    send_scan(KEY_A | RELEASE_BIT);
    send_scan(KEY_A);                    // same key after release, slot 1
    send_scan(KEY_ESC);                  // escape is stored like a letter
    send_scan(KEY_TAB);                  // so is tab
    send_scan(KEY_BACKSPACE);            // erases the tab
    send_scan(KEY_CTRL);                 // maps to nothing
    send_scan(FIRST_UNMAPPED);           // first code past the table
    send_scan(8'h7F);                    // largest make code
    send_scan(KEY_SPACE);                // last table entry
    send_scan(8'hFF);                    // largest release code
    send_scan(KEY_ENTER);                // ends the line
    send_scan(KEY_BACKSPACE);            // nothing to erase on an empty line
  endtask

  // The smallest limits: one character per line, then none at all.
  task automatic test_limit_extremes();
    write_limit(8'd1);
    send_scan(KEY_A);
    send_scan(KEY_Z);                    // line full, dropped
    send_scan(KEY_ENTER);
    write_limit(8'd0);
    send_scan(KEY_E);                    // every character is dropped
    send_scan(KEY_ENTER);
  endtask

  // A limit lowered below the current position drops characters until
  // backspaces bring the position back under it.
  task automatic test_limit_lowered();
    write_limit(8'd255);
    send_scan(KEY_A);
    send_scan(KEY_Z);
    send_scan(KEY_E);
    write_limit(8'd1);
    send_scan(KEY_R);                    // position 3, dropped
    send_scan(KEY_BACKSPACE);
    send_scan(KEY_BACKSPACE | RELEASE_BIT);
    send_scan(KEY_BACKSPACE);
    send_scan(KEY_T);                    // position 1, still dropped
    send_scan(KEY_BACKSPACE);
    send_scan(KEY_Y);                    // back under the limit, stored
  endtask

  // Long random typing under the largest limit, with Enter given no share of
  // its own so that lines run long; random codes can still end a line.
  task automatic test_fill_long_line();
    write_limit(8'd255);
    type_randomly(380, 0, 2);
  endtask

  // Short random limits, where lines fill up often.
  task automatic test_short_limits();
    write_limit(8'd1);
    type_randomly(50, 10, 10);
    write_limit(8'($urandom_range(2, 16)));
    type_randomly(90, 8, 15);
    write_limit(8'($urandom_range(2, 16)));
    type_randomly(90, 8, 15);
    write_limit(8'd0);
    type_randomly(30, 10, 10);
  endtask

  // Both sides at full rate, so the two-entry queue runs back to back.
  task automatic test_full_rate();
    write_limit(8'd255);
    no_idle = 1'b1;
    type_randomly(80, 5, 10);
    drain_events();
    no_idle = 1'b0;
  endtask

  // The receiver stalls at random except while no_idle is set.
  always @(posedge clk) begin
    out_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // Each result taken from the block is compared with the oldest prediction.
  always @(posedge clk) begin
    line_event_t got;
    line_event_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      kinds_seen[got.kind]++;
      if (expected_events.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: unexpected result kind=%0d char=%h pos=%0d", $realtime,
                   got.kind, got.ch, got.pos);
        end
      end else begin
        want = expected_events.pop_front();
        if (got.kind !== want.kind || got.ch !== want.ch || got.pos !== want.pos ||
            got.pad !== want.pad) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: mismatch kind %0d/%0d char %h/%h pos %0d/%0d pad %h/%h",
                     $realtime, want.kind, got.kind, want.ch, got.ch, want.pos, got.pos,
                     want.pad, got.pad);
          end
        end
      end
    end
  end

  initial begin
    last_make  = 8'h00;
    cursor     = 8'h00;
    line_limit = sle_pkg::MAX_LEN_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_and_keys();
    test_limit_extremes();
    test_limit_lowered();
    test_fill_long_line();
    test_short_limits();
    test_full_rate();

    drain_events();
    repeat (8) @(posedge clk);
    $display("Sent %0d scan codes under %0d limit settings.", scans_sent, limits_used);
    $display("Results: %0d none, %0d stored, %0d erased, %0d line ends.",
             kinds_seen[0], kinds_seen[1], kinds_seen[2], kinds_seen[3]);
    if (errors == 0 && expected_events.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
